@@ sv/lj_pkg.sv @@
// Shared types and constants for the Lennard-Jones pair energy block
`timescale 1ns / 1ps
package lj_pkg;

   localparam int COORD_W = 23;
   localparam int DIFF_W  = 24;
   localparam int BOX_W   = 21;
   localparam int CUT_W   = 26;
   localparam int ABS_W   = 25;
   localparam int SQ_W    = 50;
   localparam int R2_W    = 52;
   localparam int WORD_W  = 64;
   localparam int WIDE_W  = 72;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_LENGTH      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_SQ       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_ENABLE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENERGY_SHIFT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_ENABLE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_CORRECTION = 3'd5;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef struct packed {
      logic            first_item;
      logic            last_item;
      logic            in_cutoff;
      logic [R2_W-1:0] r2;
   } lj_item_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } lj_queue_status_type;

   typedef struct packed {
      logic [BOX_W-1:0] box_length;
      logic [CUT_W-1:0] cutoff_sq;
   } lj_front_cfg_type;

   typedef struct packed {
      logic              shift_enable;
      logic [WORD_W-1:0] energy_shift;
      logic              tail_enable;
      logic [WORD_W-1:0] tail_correction;
   } lj_back_cfg_type;

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_SQUARE = 3'b010,
      F_PUSH   = 3'b100
   } lj_front_state_type;

   typedef enum logic [7:0] {
      B_IDLE  = 8'b0000_0001,
      B_DIV   = 8'b0000_0010,
      B_MUL   = 8'b0000_0100,
      B_MRES  = 8'b0000_1000,
      B_TERM  = 8'b0001_0000,
      B_SHIFT = 8'b0010_0000,
      B_ACC   = 8'b0100_0000,
      B_EMIT  = 8'b1000_0000
   } lj_back_state_type;

   typedef enum logic [1:0] {
      M_UU  = 2'd0,
      M_TU  = 2'd1,
      M_SS  = 2'd2
   } lj_mul_sel_type;

endpackage

@@ sv/lj_front.sv @@
// Front end: takes pair transfers, folds displacements, sums squares, checks cutoff
`timescale 1ns / 1ps
module lj_front import lj_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_target_x,
   input  logic [COORD_W-1:0]  req_target_y,
   input  logic [COORD_W-1:0]  req_target_z,
   input  logic [COORD_W-1:0]  req_neighbor_x,
   input  logic [COORD_W-1:0]  req_neighbor_y,
   input  logic [COORD_W-1:0]  req_neighbor_z,
   input  logic                req_skip_self,
   input  logic                req_first_item,
   input  logic                req_last_item,
   input  lj_front_cfg_type    cfg,
   input  lj_queue_status_type q_status,
   output logic                push_valid,
   output lj_item_type         push_item
);

   localparam int SCALED_W = CUT_W + COORD_FRAC_BITS;
   localparam int CMP_W    = (R2_W > SCALED_W) ? R2_W : SCALED_W;

   lj_front_state_type state_ff, state_in;
   logic [1:0]        step_ff, step_in;
   logic [DIFF_W-1:0] d_ff [3];
   logic [DIFF_W-1:0] d_in [3];
   logic [ABS_W-1:0]  abs_ff, abs_in;
   logic [R2_W-1:0]   r2_ff, r2_in;
   logic              skip_ff, skip_in;
   logic              first_ff, first_in;
   logic              last_ff, last_in;

   logic [DIFF_W-1:0]  sel_d;
   logic signed [25:0] ext_d, two_d, len_s, folded;
   logic [SQ_W-1:0]    square;
   logic [CMP_W-1:0]   cut_scaled, r2_cmp;
   logic               take;

   assign req_ready = (state_ff == F_IDLE);
   assign take      = req_valid && req_ready;

   always_comb begin
      sel_d  = (step_ff == 2'd3) ? '0 : d_ff[step_ff];
      ext_d  = $signed({{2{sel_d[DIFF_W-1]}}, sel_d});
      two_d  = ext_d <<< 1;
      len_s  = $signed({5'b0, cfg.box_length});
      if (two_d > len_s) begin
         folded = ext_d - len_s;
      end else if (two_d < -len_s) begin
         folded = ext_d + len_s;
      end else begin
         folded = ext_d;
      end
      abs_in = folded[25] ? ABS_W'(-folded) : ABS_W'(folded);
      square = abs_ff * abs_ff;
   end

   always_comb begin
      cut_scaled = CMP_W'(cfg.cutoff_sq) << COORD_FRAC_BITS;
      r2_cmp     = CMP_W'(r2_ff);
      push_valid = (state_ff == F_PUSH);
      push_item.first_item = first_ff;
      push_item.last_item  = last_ff;
      push_item.in_cutoff  = !skip_ff && (r2_cmp < cut_scaled);
      push_item.r2         = r2_ff;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      d_in     = d_ff;
      r2_in    = r2_ff;
      skip_in  = skip_ff;
      first_in = first_ff;
      last_in  = last_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (take) begin
               d_in[0]  = {req_target_x[COORD_W-1], req_target_x}
                        - {req_neighbor_x[COORD_W-1], req_neighbor_x};
               d_in[1]  = {req_target_y[COORD_W-1], req_target_y}
                        - {req_neighbor_y[COORD_W-1], req_neighbor_y};
               d_in[2]  = {req_target_z[COORD_W-1], req_target_z}
                        - {req_neighbor_z[COORD_W-1], req_neighbor_z};
               skip_in  = req_skip_self;
               first_in = req_first_item;
               last_in  = req_last_item;
               step_in  = 2'd0;
               r2_in    = '0;
               state_in = F_SQUARE;
            end
         end
         F_SQUARE: begin
            if (step_ff != 2'd0) begin
               r2_in = r2_ff + R2_W'(square);
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (q_status.not_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      d_ff     <= d_in;
      abs_ff   <= abs_in;
      r2_ff    <= r2_in;
      skip_ff  <= skip_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

endmodule

@@ sv/lj_queue.sv @@
// Short queue of classified pairs between front and back
`timescale 1ns / 1ps
module lj_queue import lj_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  lj_item_type         push_item,
   input  logic                pop,
   output lj_item_type         head_item,
   output lj_queue_status_type q_status
);

   lj_item_type        mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      q_status.not_empty = (count_ff != '0);
      q_status.not_full  = (count_ff != Q_CNT_W'(Q_DEPTH));
      do_push   = push_valid && q_status.not_full;
      do_pop    = pop && q_status.not_empty;
      head_item = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ sv/lj_back.sv @@
// Back end: reciprocal, power chain, saturating sums and result register
`timescale 1ns / 1ps
module lj_back import lj_pkg::*; #(
   parameter int COORD_FRAC_BITS  = 16,
   parameter int ENERGY_FRAC_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  lj_queue_status_type q_status,
   input  lj_item_type         head_item,
   output logic                pop,
   input  lj_back_cfg_type     cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_energy,
   output logic [WORD_W-1:0]   rsp_virial,
   output logic                rsp_saturated
);

   localparam int K     = 2 * COORD_FRAC_BITS + ENERGY_FRAC_BITS;
   localparam int CNT_W = $clog2(K + 1);
   localparam int E     = ENERGY_FRAC_BITS;
   localparam logic [WORD_W-1:0] U63MAX = {1'b0, {(WORD_W-1){1'b1}}};

   function automatic logic [WORD_W:0] sat_word(input logic [WIDE_W-1:0] x);
      logic [WORD_W:0] r;
      if (x[WIDE_W-1:WORD_W-1] == {(WIDE_W-WORD_W+1){x[WORD_W-1]}}) begin
         r = {1'b0, x[WORD_W-1:0]};
      end else if (x[WIDE_W-1]) begin
         r = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = {1'b1, U63MAX};
      end
      return r;
   endfunction

   function automatic logic [WIDE_W-1:0] sext(input logic [WORD_W-1:0] v);
      return {{(WIDE_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

   lj_back_state_type state_ff, state_in;
   lj_item_type       item_ff, item_in;
   lj_mul_sel_type    sel_ff, sel_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        step_ff, step_in;
   logic [R2_W-1:0]   rem_ff, rem_in;
   logic [62:0]       quo_ff, quo_in;
   logic              dsat_ff, dsat_in;
   logic [127:0]      prod_ff, prod_in;
   logic [WORD_W-1:0] u_ff, u_in, t_ff, t_in, s_ff, s_in, q_ff, q_in;
   logic [WORD_W-1:0] et_ff, et_in, vt_ff, vt_in;
   logic [WORD_W-1:0] esum_ff, esum_in, vsum_ff, vsum_in;
   logic              sat_ff, sat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_energy_ff, rsp_energy_in, rsp_virial_ff, rsp_virial_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic [R2_W:0]       rem_sh;
   logic                ge;
   logic [WORD_W-1:0]   ma, mb, partial;
   logic [127:0]        partial_sh;
   logic [WORD_W-1:0]   mres;
   logic                msat;
   logic [WORD_W-1:0]   diff_e, diff_v;
   logic [WIDE_W-1:0]   de, dv;
   logic [WORD_W:0]     r_e, r_v, r_s, r_ea, r_va, r_t;
   logic                out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_energy    = rsp_energy_ff;
   assign rsp_virial    = rsp_virial_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign pop           = (state_ff == B_IDLE) && q_status.not_empty;

   always_comb begin
      rem_sh = {rem_ff, (cnt_ff == CNT_W'(K))};
      ge     = rem_sh >= {1'b0, item_ff.r2};
      unique case (sel_ff)
         M_UU:    begin ma = u_ff; mb = u_ff; end
         M_TU:    begin ma = t_ff; mb = u_ff; end
         M_SS:    begin ma = s_ff; mb = s_ff; end
         default: begin ma = s_ff; mb = s_ff; end
      endcase
      unique case (step_ff)
         2'd0: partial = ma[31:0]  * mb[31:0];
         2'd1: partial = ma[31:0]  * mb[63:32];
         2'd2: partial = ma[63:32] * mb[31:0];
         default: partial = ma[63:32] * mb[63:32];
      endcase
      unique case (step_ff)
         2'd0:    partial_sh = {64'b0, partial};
         2'd3:    partial_sh = {partial, 64'b0};
         default: partial_sh = {32'b0, partial, 32'b0};
      endcase
      msat   = |prod_ff[127:E+63];
      mres   = msat ? U63MAX : {1'b0, prod_ff[E+62:E]};
      diff_e = q_ff - s_ff;
      diff_v = q_ff - {1'b0, s_ff[WORD_W-1:1]};
      de     = sext(diff_e) <<< 2;
      dv     = (sext(diff_v) <<< 5) + (sext(diff_v) <<< 4);
      r_e    = sat_word(de);
      r_v    = sat_word(dv);
      r_s    = sat_word(sext(et_ff) - sext(cfg.energy_shift));
      r_ea   = sat_word(sext(esum_ff) + sext(et_ff));
      r_va   = sat_word(sext(vsum_ff) + sext(vt_ff));
      r_t    = sat_word(sext(esum_ff) + sext(cfg.tail_correction));
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      sel_in        = sel_ff;
      cnt_in        = cnt_ff;
      step_in       = step_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dsat_in       = dsat_ff;
      prod_in       = prod_ff;
      u_in          = u_ff;
      t_in          = t_ff;
      s_in          = s_ff;
      q_in          = q_ff;
      et_in         = et_ff;
      vt_in         = vt_ff;
      esum_in       = esum_ff;
      vsum_in       = vsum_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_energy_in = rsp_energy_ff;
      rsp_virial_in = rsp_virial_ff;
      rsp_sat_in    = rsp_sat_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop) begin
               item_in = head_item;
               if (head_item.first_item) begin
                  esum_in = '0;
                  vsum_in = '0;
                  sat_in  = 1'b0;
               end
               cnt_in  = CNT_W'(K);
               rem_in  = '0;
               quo_in  = '0;
               dsat_in = (head_item.r2 == '0);
               if (head_item.in_cutoff) begin
                  state_in = B_DIV;
               end else if (head_item.last_item) begin
                  state_in = B_EMIT;
               end
            end
         end
         B_DIV: begin
            if (quo_ff[62]) begin
               dsat_in = 1'b1;
            end
            quo_in = {quo_ff[61:0], ge};
            rem_in = ge ? R2_W'(rem_sh - {1'b0, item_ff.r2}) : rem_sh[R2_W-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (dsat_ff || quo_ff[62]) begin
                  u_in   = U63MAX;
                  sat_in = 1'b1;
               end else begin
                  u_in = {1'b0, quo_ff[61:0], ge};
               end
               sel_in   = M_UU;
               step_in  = 2'd0;
               prod_in  = '0;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            prod_in = prod_ff + partial_sh;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = B_MRES;
            end
         end
         B_MRES: begin
            if (msat) begin
               sat_in = 1'b1;
            end
            prod_in = '0;
            step_in = 2'd0;
            unique case (sel_ff)
               M_UU: begin
                  t_in     = mres;
                  sel_in   = M_TU;
                  state_in = B_MUL;
               end
               M_TU: begin
                  s_in     = mres;
                  sel_in   = M_SS;
                  state_in = B_MUL;
               end
               default: begin
                  q_in     = mres;
                  state_in = B_TERM;
               end
            endcase
         end
         B_TERM: begin
            et_in    = r_e[WORD_W-1:0];
            vt_in    = r_v[WORD_W-1:0];
            sat_in   = sat_ff | r_e[WORD_W] | r_v[WORD_W];
            state_in = B_SHIFT;
         end
         B_SHIFT: begin
            if (cfg.shift_enable) begin
               et_in  = r_s[WORD_W-1:0];
               sat_in = sat_ff | r_s[WORD_W];
            end
            state_in = B_ACC;
         end
         B_ACC: begin
            esum_in  = r_ea[WORD_W-1:0];
            vsum_in  = r_va[WORD_W-1:0];
            sat_in   = sat_ff | r_ea[WORD_W] | r_va[WORD_W];
            state_in = item_ff.last_item ? B_EMIT : B_IDLE;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_virial_in = vsum_ff;
               if (cfg.tail_enable) begin
                  rsp_energy_in = r_t[WORD_W-1:0];
                  rsp_sat_in    = sat_ff | r_t[WORD_W];
               end else begin
                  rsp_energy_in = esum_ff;
                  rsp_sat_in    = sat_ff;
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         esum_ff      <= '0;
         vsum_ff      <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         esum_ff      <= esum_in;
         vsum_ff      <= vsum_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff       <= item_in;
      sel_ff        <= sel_in;
      cnt_ff        <= cnt_in;
      step_ff       <= step_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dsat_ff       <= dsat_in;
      prod_ff       <= prod_in;
      u_ff          <= u_in;
      t_ff          <= t_in;
      s_ff          <= s_in;
      q_ff          <= q_in;
      et_ff         <= et_in;
      vt_ff         <= vt_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_virial_ff <= rsp_virial_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

endmodule

@@ sv/lennard_jones_pair_energy.sv @@
// Top level of the Lennard-Jones pair energy and virial accumulator
`timescale 1ns / 1ps
// Pairs enter on the req_ channel; the front end folds each displacement
// once into the periodic box and sums the squares, taking no new pair until
// it hands the pair to a two-entry queue. The back end pops a pair outside
// the cutoff or skipped and moves on (to emission on a last_item pair); on a
// pair inside the cutoff the restoring divider that forms 1/r2 yields one
// quotient bit per cycle, and the three 64x64 products share one 32x32
// multiplier, each built from four partial products. A last_item pair
// places energy, virial and the saturation flag in an output register that
// holds them on rsp_ until taken; sums are kept after emission and cleared
// only by first_item or reset. Registers are written through csr_; the user
// must write them only while idle, as the block does not enforce it.
module lennard_jones_pair_energy import lj_pkg::*; #(
   parameter int COORD_FRAC_BITS  = 16,
   parameter int ENERGY_FRAC_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_W-1:0]     req_target_x,
   input  logic [COORD_W-1:0]     req_target_y,
   input  logic [COORD_W-1:0]     req_target_z,
   input  logic [COORD_W-1:0]     req_neighbor_x,
   input  logic [COORD_W-1:0]     req_neighbor_y,
   input  logic [COORD_W-1:0]     req_neighbor_z,
   input  logic                   req_skip_self,
   input  logic                   req_first_item,
   input  logic                   req_last_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [WORD_W-1:0]      rsp_energy,
   output logic [WORD_W-1:0]      rsp_virial,
   output logic                   rsp_saturated,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_data
);

   logic [BOX_W-1:0]  box_length_ff;
   logic [CUT_W-1:0]  cutoff_sq_ff;
   logic              shift_enable_ff;
   logic [WORD_W-1:0] energy_shift_ff;
   logic              tail_enable_ff;
   logic [WORD_W-1:0] tail_correction_ff;

   lj_front_cfg_type    front_cfg;
   lj_back_cfg_type     back_cfg;
   lj_queue_status_type q_status;
   lj_item_type         push_item, head_item;
   logic                push_valid, pop;

   always_comb begin
      front_cfg.box_length     = box_length_ff;
      front_cfg.cutoff_sq      = cutoff_sq_ff;
      back_cfg.shift_enable    = shift_enable_ff;
      back_cfg.energy_shift    = energy_shift_ff;
      back_cfg.tail_enable     = tail_enable_ff;
      back_cfg.tail_correction = tail_correction_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff      <= BOX_W'(495616);
         cutoff_sq_ff       <= CUT_W'(802816);
         shift_enable_ff    <= 1'b0;
         energy_shift_ff    <= '0;
         tail_enable_ff     <= 1'b0;
         tail_correction_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BOX_LENGTH:      box_length_ff      <= csr_data[BOX_W-1:0];
            CSR_CUTOFF_SQ:       cutoff_sq_ff       <= csr_data[CUT_W-1:0];
            CSR_SHIFT_ENABLE:    shift_enable_ff    <= csr_data[0];
            CSR_ENERGY_SHIFT:    energy_shift_ff    <= csr_data;
            CSR_TAIL_ENABLE:     tail_enable_ff     <= csr_data[0];
            CSR_TAIL_CORRECTION: tail_correction_ff <= csr_data;
            default: ;
         endcase
      end
   end

   lj_front #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_target_x   (req_target_x),
      .req_target_y   (req_target_y),
      .req_target_z   (req_target_z),
      .req_neighbor_x (req_neighbor_x),
      .req_neighbor_y (req_neighbor_y),
      .req_neighbor_z (req_neighbor_z),
      .req_skip_self  (req_skip_self),
      .req_first_item (req_first_item),
      .req_last_item  (req_last_item),
      .cfg            (front_cfg),
      .q_status       (q_status),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   lj_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .q_status   (q_status)
   );

   lj_back #(
      .COORD_FRAC_BITS  (COORD_FRAC_BITS),
      .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head_item     (head_item),
      .pop           (pop),
      .cfg           (back_cfg),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_energy    (rsp_energy),
      .rsp_virial    (rsp_virial),
      .rsp_saturated (rsp_saturated)
   );

endmodule

@@ sv/lj_checker.sv @@
// Port-level checks for the Lennard-Jones pair energy block, bound to the top
`timescale 1ns / 1ps
module lj_checker import lj_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] rsp_energy,
   input logic [WORD_W-1:0] rsp_virial,
   input logic              rsp_saturated
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_energy) && $stable(rsp_virial) && $stable(rsp_saturated))
      else $error("result payload changed while stalled");

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("front took a second pair while still folding");

endmodule

bind lennard_jones_pair_energy lj_checker u_lj_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_energy    (rsp_energy),
   .rsp_virial    (rsp_virial),
   .rsp_saturated (rsp_saturated)
);
